// ===== src/dap_pkg.sv =====
package dap_pkg;

    // Field widths
    localparam int ANGLE_W = 26;
    localparam int MAG_W   = 25;
    localparam int FINE_W  = 20;

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_W  = 8'h57;
    localparam logic [7:0] CH_LO_W  = 8'h77;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_LO_S  = 8'h73;

    // Accumulator and digit-count saturation tops, and the fraction digit limit
    localparam logic [9:0] DEG_TOP  = 10'd255;
    localparam logic [9:0] MIN_TOP  = 10'd127;
    localparam logic [9:0] TAIL_TOP = 10'd1023;
    localparam logic [2:0] CNT_MAX  = 3'd7;
    localparam logic [2:0] MAX_FRAC = 3'd3;

    // Range limits
    localparam logic [7:0] LAT_LIMIT = 8'd90;
    localparam logic [7:0] LON_LIMIT = 8'd180;
    localparam logic [9:0] BASE60    = 10'd60;

    // Units of 1/180000 degree
    localparam logic [17:0] DEG_UNITS = 18'd180000;
    localparam logic [11:0] MIN_UNITS = 12'd3000;
    localparam logic [8:0]  SEC_UNITS = 9'd50;
    localparam logic [8:0]  F1_UNITS  = 9'd300;
    localparam logic [8:0]  F2_UNITS  = 9'd30;
    localparam logic [8:0]  F3_UNITS  = 9'd3;

    typedef enum logic [1:0] {
        PH_DEG,
        PH_MIN,
        PH_TAIL,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        SC_SEC,
        SC_F1,
        SC_F2,
        SC_F3
    } t_scale;

    // Closed field handed from the scanner to the scaler
    typedef struct packed {
        logic       ok;
        logic       neg;
        logic [7:0] deg;
        logic [6:0] min;
        logic [9:0] tail;
        t_scale     scale;
    } t_close;

    // One decimal digit into a saturating accumulator
    function automatic logic [9:0] sat_dec(input logic [9:0] acc, input logic [3:0] d,
                                           input logic [9:0] top);
        logic [13:0] v;
        v = 14'(acc) * 14'd10 + 14'(d);
        return (v > 14'(top)) ? top : v[9:0];
    endfunction

endpackage

// ===== src/dap_if.sv =====
interface dap_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       is_latitude;
    logic       last_char;

    modport source (output valid, character, is_latitude, last_char, input ready);
    modport sink   (input valid, character, is_latitude, last_char, output ready);
endinterface

interface dap_result_if;
    logic               valid;
    logic               ready;
    logic               parse_ok;
    logic signed [25:0] angle_value;

    modport source (output valid, parse_ok, angle_value, input ready);
    modport sink   (input valid, parse_ok, angle_value, output ready);
endinterface

// ===== src/dms_angle_text_parser_unit.sv =====
// Channel    Dir  Payload                                   Ends on
// i_char     in   character[8], is_latitude, last_char      valid && ready
// o_result   out  parse_ok, angle_value[26] signed           valid && ready
//
// One character per cycle while i_char.ready is high; a result leaves once the request that
// carries last_char has passed the scan register, product register and result register.
// Characters without last_char update the scanner state and give no result.
// Reset (i_rst_n low, synchronous) returns the scanner to the degrees phase
// and empties all pipeline registers.
// A stalled o_result holds the pipeline back one stage at a time; i_char.ready
// drops only when the closed-field register is full and cannot advance.
module dms_angle_text_parser_unit
    import dap_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dap_char_if.sink      i_char,
    dap_result_if.source  o_result
);

    logic   s1_valid;
    t_close s1_close;
    logic   s1_adv;
    logic   take;

    // Accept a request whenever the closed-field register is empty or moving on
    assign i_char.ready = !s1_valid || s1_adv;
    assign take         = i_char.valid && i_char.ready;

    // Character scanner: per-character parse and field close
    dap_scan u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_character   (i_char.character),
        .i_is_latitude (i_char.is_latitude),
        .i_last_char   (i_char.last_char),
        .i_adv         (s1_adv),
        .o_valid       (s1_valid),
        .o_close       (s1_close)
    );

    // Scaler: constant products, then sum and sign into the result register
    dap_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s1_valid),
        .i_close       (s1_close),
        .i_out_ready   (o_result.ready),
        .o_take        (s1_adv),
        .o_valid       (o_result.valid),
        .o_parse_ok    (o_result.parse_ok),
        .o_angle_value (o_result.angle_value)
    );

`ifndef SYNTHESIS
    // A rejected field reads as zero
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.parse_ok |-> o_result.angle_value == 26'sd0)
        else $error("rejected field with nonzero angle");

    // An accepted field stays within the clamped range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.parse_ok |->
            (o_result.angle_value <= 26'sd32580000 &&
             o_result.angle_value >= -26'sd32580000))
        else $error("angle outside range");

    // A closing character always loads the closed-field register
    a_close_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && i_char.last_char |=> s1_valid)
        else $error("closing character lost");
`endif

endmodule

// ===== src/dap_scan.sv =====
module dap_scan
    import dap_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_character,
    input  logic       i_is_latitude,
    input  logic       i_last_char,
    input  logic       i_adv,
    output logic       o_valid,
    output t_close     o_close
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_deg, n_deg;
    logic [6:0] r_min, n_min;
    logic [9:0] r_tail, n_tail;
    logic [2:0] r_cnt, n_cnt, cnt_inc;
    logic       r_sec, n_sec;
    logic       r_neg, n_neg;
    logic       r_err, n_err;
    logic       r_valid;
    t_close     r_close, n_close;
    logic       dig;
    logic [3:0] d;
    logic [7:0] lim;

    assign dig     = i_character inside {[CH_0:CH_9]};
    assign d       = dig ? 4'(i_character - CH_0) : 4'd0;
    assign cnt_inc = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 3'd1;

    always_comb begin
        n_phase = r_phase;
        n_deg   = r_deg;
        n_min   = r_min;
        n_tail  = r_tail;
        n_cnt   = r_cnt;
        n_sec   = r_sec;
        n_neg   = r_neg;
        n_err   = r_err;
        if (!r_err) begin
            case (r_phase)
                PH_DEG: begin
                    if (dig) begin
                        n_deg = 8'(sat_dec(10'(r_deg), d, DEG_TOP));
                        n_cnt = cnt_inc;
                    end else if (i_character == CH_COLON && r_cnt != 3'd0) begin
                        n_phase = PH_MIN;
                        n_cnt   = 3'd0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_MIN: begin
                    if (dig) begin
                        n_min = 7'(sat_dec(10'(r_min), d, MIN_TOP));
                        n_cnt = cnt_inc;
                    end else if ((i_character == CH_COLON || i_character == CH_DOT)
                                 && r_cnt != 3'd0) begin
                        n_sec   = (i_character == CH_COLON);
                        n_phase = PH_TAIL;
                        n_cnt   = 3'd0;
                    end else begin
                        n_err = 1'b1;
                    end
                end
                PH_TAIL: begin
                    if (dig) begin
                        n_tail = sat_dec(r_tail, d, TAIL_TOP);
                        n_cnt  = cnt_inc;
                    end else if (r_cnt == 3'd0) begin
                        n_err = 1'b1;
                    end else begin
                        n_neg   = i_character inside {CH_UP_W, CH_LO_W, CH_UP_S, CH_LO_S};
                        n_phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
    end

    // Close the field from the state that includes the last character
    always_comb begin
        lim = i_is_latitude ? LAT_LIMIT : LON_LIMIT;
        n_close.ok = !n_err && (n_phase == PH_TAIL || n_phase == PH_DONE)
                     && n_cnt != 3'd0 && 10'(n_min) < BASE60
                     && (n_sec ? (n_tail < BASE60) : (n_cnt <= MAX_FRAC));
        n_close.neg  = n_neg;
        n_close.deg  = (n_deg > lim) ? lim : n_deg;
        n_close.min  = n_min;
        n_close.tail = n_tail;
        if (n_sec)
            n_close.scale = SC_SEC;
        else if (n_cnt == 3'd1)
            n_close.scale = SC_F1;
        else if (n_cnt == 3'd2)
            n_close.scale = SC_F2;
        else
            n_close.scale = SC_F3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DEG;
            r_deg   <= '0;
            r_min   <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_sec   <= 1'b0;
            r_neg   <= 1'b0;
            r_err   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_take && i_last_char) begin
                r_phase <= PH_DEG;
                r_deg   <= '0;
                r_min   <= '0;
                r_tail  <= '0;
                r_cnt   <= '0;
                r_sec   <= 1'b0;
                r_neg   <= 1'b0;
                r_err   <= 1'b0;
                r_valid <= 1'b1;
            end else begin
                if (i_take) begin
                    r_phase <= n_phase;
                    r_deg   <= n_deg;
                    r_min   <= n_min;
                    r_tail  <= n_tail;
                    r_cnt   <= n_cnt;
                    r_sec   <= n_sec;
                    r_neg   <= n_neg;
                    r_err   <= n_err;
                end
                if (i_adv)
                    r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last_char)
            r_close <= n_close;
    end

    assign o_valid = r_valid;
    assign o_close = r_close;

endmodule

// ===== src/dap_scale.sv =====
module dap_scale
    import dap_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  t_close                     i_close,
    input  logic                       i_out_ready,
    output logic                       o_take,
    output logic                       o_valid,
    output logic                       o_parse_ok,
    output logic signed [ANGLE_W-1:0]  o_angle_value
);

    logic                r_s2_valid;
    logic                r_s2_ok, r_s2_neg;
    logic [MAG_W-1:0]    r_deg_term, n_deg_term;
    logic [FINE_W-1:0]   r_fine_term, n_fine_term;
    logic [8:0]          k;
    logic                r_o_valid, r_o_ok;
    logic [ANGLE_W-1:0]  r_o_angle, n_angle;
    logic [MAG_W-1:0]    mag;
    logic                out_move, s2_move;

    assign out_move = !r_o_valid || i_out_ready;
    assign s2_move  = !r_s2_valid || out_move;
    assign o_take   = s2_move;

    always_comb begin
        case (i_close.scale)
            SC_SEC:  k = SEC_UNITS;
            SC_F1:   k = F1_UNITS;
            SC_F2:   k = F2_UNITS;
            default: k = F3_UNITS;
        endcase
        if (i_close.ok) begin
            n_deg_term  = MAG_W'(i_close.deg) * MAG_W'(DEG_UNITS);
            n_fine_term = FINE_W'(i_close.min) * FINE_W'(MIN_UNITS)
                        + FINE_W'(i_close.tail) * FINE_W'(k);
        end else begin
            n_deg_term  = '0;
            n_fine_term = '0;
        end
    end

    assign mag     = r_deg_term + MAG_W'(r_fine_term);
    assign n_angle = r_s2_neg ? ANGLE_W'(0) - {1'b0, mag} : {1'b0, mag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (s2_move)
                r_s2_valid <= i_valid;
            if (out_move)
                r_o_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move && i_valid) begin
            r_s2_ok     <= i_close.ok;
            r_s2_neg    <= i_close.neg;
            r_deg_term  <= n_deg_term;
            r_fine_term <= n_fine_term;
        end
        if (out_move && r_s2_valid) begin
            r_o_ok    <= r_s2_ok;
            r_o_angle <= n_angle;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_parse_ok    = r_o_ok;
    assign o_angle_value = $signed(r_o_angle);

endmodule
